// ===== hw/rtl/ryc_pkg.sv =====
package ryc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int DELTA_W    = 16;
    localparam int OPND_W     = DELTA_W + 2;          // luma + delta needs 18 signed bits
    localparam int WEIGHT_W   = 21;
    localparam int NUM_TERMS  = 3;
    localparam int WVEC_W     = WEIGHT_W * NUM_TERMS;
    localparam int OFFSET_W   = 40;
    localparam int PROD_W     = WEIGHT_W + OPND_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int XSHIFT_W   = 4;
    localparam int DEPTH_W    = 5;
    localparam int SH_W       = $clog2(FRAC_BITS + (1 << XSHIFT_W));
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WVEC_W;
    localparam int LATENCY    = 4;
    localparam int DEPTH_LOW  = 8;
    localparam int DEPTH_HIGH = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Y_WEIGHTS     = 3'd0,
        CFG_U_WEIGHTS     = 3'd1,
        CFG_V_WEIGHTS     = 3'd2,
        CFG_Y_OFFSET      = 3'd3,
        CFG_U_OFFSET      = 3'd4,
        CFG_V_OFFSET      = 3'd5,
        CFG_EXTRA_SHIFT   = 3'd6,
        CFG_OUT_BIT_DEPTH = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                       op;
        logic [SAMPLE_W-1:0]        luma_sample;
        logic signed [DELTA_W-1:0]  delta_r;
        logic signed [DELTA_W-1:0]  delta_g;
        logic signed [DELTA_W-1:0]  delta_b;
        logic                       row_end;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] main_value;
        logic [SAMPLE_W-1:0] second_value;
        logic                row_done;
    } t_out;

    typedef struct packed {
        logic [WVEC_W-1:0]          y_w;
        logic [WVEC_W-1:0]          u_w;
        logic [WVEC_W-1:0]          v_w;
        logic signed [OFFSET_W-1:0] y_off;
        logic signed [OFFSET_W-1:0] u_off;
        logic signed [OFFSET_W-1:0] v_off;
        logic [SH_W-1:0]            sh;
        logic [SAMPLE_W-1:0]        max_value;
    } t_cfg;

endpackage

// ===== hw/rtl/ryc_cfg_regs.sv =====
module ryc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ryc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ryc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output ryc_pkg::t_cfg                      o_cfg
);

    logic [ryc_pkg::WVEC_W-1:0]          r_y_w, r_u_w, r_v_w;
    logic signed [ryc_pkg::OFFSET_W-1:0] r_y_off, r_u_off, r_v_off;
    logic [ryc_pkg::XSHIFT_W-1:0]        r_xshift;
    logic [ryc_pkg::DEPTH_W-1:0]         r_depth;
    logic [ryc_pkg::SAMPLE_W-1:0]        max_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_w    <= '0;
            r_u_w    <= '0;
            r_v_w    <= '0;
            r_y_off  <= '0;
            r_u_off  <= '0;
            r_v_off  <= '0;
            r_xshift <= '0;
            r_depth  <= ryc_pkg::DEPTH_RESET;
        end else if (i_cfg_we) begin
            unique case (ryc_pkg::t_cfg_idx'(i_cfg_idx))
                ryc_pkg::CFG_Y_WEIGHTS:     r_y_w <= i_cfg_wdata[ryc_pkg::WVEC_W-1:0];
                ryc_pkg::CFG_U_WEIGHTS:     r_u_w <= i_cfg_wdata[ryc_pkg::WVEC_W-1:0];
                ryc_pkg::CFG_V_WEIGHTS:     r_v_w <= i_cfg_wdata[ryc_pkg::WVEC_W-1:0];
                ryc_pkg::CFG_Y_OFFSET:      r_y_off <= i_cfg_wdata[ryc_pkg::OFFSET_W-1:0];
                ryc_pkg::CFG_U_OFFSET:      r_u_off <= i_cfg_wdata[ryc_pkg::OFFSET_W-1:0];
                ryc_pkg::CFG_V_OFFSET:      r_v_off <= i_cfg_wdata[ryc_pkg::OFFSET_W-1:0];
                ryc_pkg::CFG_EXTRA_SHIFT:   r_xshift <= i_cfg_wdata[ryc_pkg::XSHIFT_W-1:0];
                ryc_pkg::CFG_OUT_BIT_DEPTH: r_depth <= i_cfg_wdata[ryc_pkg::DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // clip ceiling: 255 up to depth 8, saturates at the field width past 16
    always_comb begin
        if (r_depth <= ryc_pkg::DEPTH_W'(ryc_pkg::DEPTH_LOW)) begin
            max_value = ryc_pkg::SAMPLE_W'(255);
        end else if (r_depth >= ryc_pkg::DEPTH_W'(ryc_pkg::DEPTH_HIGH)) begin
            max_value = '1;
        end else begin
            max_value = ryc_pkg::SAMPLE_W'((32'd1 << r_depth) - 32'd1);
        end
    end

    assign o_cfg.y_w       = r_y_w;
    assign o_cfg.u_w       = r_u_w;
    assign o_cfg.v_w       = r_v_w;
    assign o_cfg.y_off     = r_y_off;
    assign o_cfg.u_off     = r_u_off;
    assign o_cfg.v_off     = r_v_off;
    assign o_cfg.sh        = ryc_pkg::SH_W'(ryc_pkg::FRAC_BITS) + ryc_pkg::SH_W'(r_xshift);
    assign o_cfg.max_value = max_value;

endmodule

// ===== hw/rtl/ryc_lane.sv =====
module ryc_lane (
    input  logic                                i_clk,
    input  logic [ryc_pkg::WVEC_W-1:0]          i_w,
    input  logic signed [ryc_pkg::OFFSET_W-1:0] i_off,
    input  logic [ryc_pkg::SH_W-1:0]            i_sh,
    input  logic [ryc_pkg::SAMPLE_W-1:0]        i_max,
    input  logic signed [ryc_pkg::OPND_W-1:0]   i_r,
    input  logic signed [ryc_pkg::OPND_W-1:0]   i_g,
    input  logic signed [ryc_pkg::OPND_W-1:0]   i_b,
    output logic [ryc_pkg::SAMPLE_W-1:0]        o_value
);

    logic signed [ryc_pkg::OPND_W-1:0]   opnd [ryc_pkg::NUM_TERMS];
    logic signed [ryc_pkg::PROD_W-1:0]   r_prod [ryc_pkg::NUM_TERMS];
    logic signed [ryc_pkg::ACC_W-1:0]    r_bias;
    logic signed [ryc_pkg::ACC_W-1:0]    r_sum;
    logic [ryc_pkg::SAMPLE_W-1:0]        r_value;
    logic [ryc_pkg::ACC_W-1:0]           half;
    logic signed [ryc_pkg::ACC_W-1:0]    shifted;
    logic signed [ryc_pkg::ACC_W-1:0]    limit;
    logic [ryc_pkg::SAMPLE_W-1:0]        n_value;

    assign opnd[0] = i_r;
    assign opnd[1] = i_g;
    assign opnd[2] = i_b;

    // rounding half: 2^(sh-1)
    assign half = {{(ryc_pkg::ACC_W-1){1'b0}}, 1'b1} << (i_sh - ryc_pkg::SH_W'(1));

    // stage: products and bias
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ryc_pkg::NUM_TERMS; k++) begin
            r_prod[k] <= $signed(i_w[k*ryc_pkg::WEIGHT_W +: ryc_pkg::WEIGHT_W]) * opnd[k];
        end
        r_bias <= ryc_pkg::ACC_W'(i_off) + $signed(half);
    end

    // stage: sum
    always_ff @(posedge i_clk) begin
        r_sum <= ryc_pkg::ACC_W'(r_prod[0]) + ryc_pkg::ACC_W'(r_prod[1])
               + ryc_pkg::ACC_W'(r_prod[2]) + r_bias;
    end

    // stage: floor shift and clip
    assign shifted = r_sum >>> i_sh;
    assign limit   = $signed({{(ryc_pkg::ACC_W-ryc_pkg::SAMPLE_W){1'b0}}, i_max});

    always_comb begin
        if (shifted < 0) begin
            n_value = '0;
        end else if (shifted > limit) begin
            n_value = i_max;
        end else begin
            n_value = shifted[ryc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== hw/rtl/rgb_to_yuv_matrix_convert_top.sv =====
// Channel    Handshake            Payload
// input      start / busy         i_data  (ryc_pkg::t_in)
// result     o_valid (strobe)     o_data  (ryc_pkg::t_out)
// config     i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// One sample per cycle; a result strobes once its transaction has passed the
// operand build, multiply, sum and shift/clip registers.
// busy stays low: the pipeline never holds off a transaction.
// Synchronous reset clears the valid pipeline and the config registers (output bit depth resets to 8).
// The receiver cannot stall; every result shows for one cycle only.
module rgb_to_yuv_matrix_convert_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ryc_pkg::t_in                    i_data,
    output logic                            o_valid,
    output ryc_pkg::t_out                   o_data,
    input  logic                            i_cfg_we,
    input  logic [ryc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ryc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    ryc_pkg::t_cfg cfg;

    logic                                accept;
    logic signed [ryc_pkg::OPND_W-1:0]   luma_ext;
    logic signed [ryc_pkg::OPND_W-1:0]   n_r, n_g, n_b;
    logic signed [ryc_pkg::OPND_W-1:0]   r_r, r_g, r_b;
    logic [ryc_pkg::LATENCY-1:0]         r_vld;
    logic [ryc_pkg::LATENCY-1:0]         r_op;
    logic [ryc_pkg::LATENCY-1:0]         r_row;
    logic [ryc_pkg::WVEC_W-1:0]          w_a;
    logic signed [ryc_pkg::OFFSET_W-1:0] off_a;
    logic [ryc_pkg::SAMPLE_W-1:0]        value_a, value_b;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ryc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // operand build: luma mode adds the luma sample to each delta
    assign luma_ext = $signed({2'b00, i_data.luma_sample});

    always_comb begin
        n_r = ryc_pkg::OPND_W'(i_data.delta_r);
        n_g = ryc_pkg::OPND_W'(i_data.delta_g);
        n_b = ryc_pkg::OPND_W'(i_data.delta_b);
        if (!i_data.op) begin
            n_r = n_r + luma_ext;
            n_g = n_g + luma_ext;
            n_b = n_b + luma_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r   <= n_r;
        r_g   <= n_g;
        r_b   <= n_b;
        r_op  <= {r_op[ryc_pkg::LATENCY-2:0], i_data.op};
        r_row <= {r_row[ryc_pkg::LATENCY-2:0], i_data.row_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ryc_pkg::LATENCY-2:0], accept};
        end
    end

    // lane A gives Y or U, lane B gives V
    assign w_a   = r_op[0] ? cfg.u_w   : cfg.y_w;
    assign off_a = r_op[0] ? cfg.u_off : cfg.y_off;

    ryc_lane u_lane_a (
        .i_clk   (i_clk),
        .i_w     (w_a),
        .i_off   (off_a),
        .i_sh    (cfg.sh),
        .i_max   (cfg.max_value),
        .i_r     (r_r),
        .i_g     (r_g),
        .i_b     (r_b),
        .o_value (value_a)
    );

    ryc_lane u_lane_b (
        .i_clk   (i_clk),
        .i_w     (cfg.v_w),
        .i_off   (cfg.v_off),
        .i_sh    (cfg.sh),
        .i_max   (cfg.max_value),
        .i_r     (r_r),
        .i_g     (r_g),
        .i_b     (r_b),
        .o_value (value_b)
    );

    assign o_valid             = r_vld[ryc_pkg::LATENCY-1];
    assign o_data.main_value   = value_a;
    assign o_data.second_value = r_op[ryc_pkg::LATENCY-1] ? value_b : '0;
    assign o_data.row_done     = r_row[ryc_pkg::LATENCY-1];

endmodule

// ===== hw/rtl/ryc_checker.sv =====
module ryc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  ryc_pkg::t_in  i_data,
    input  logic          o_valid,
    input  ryc_pkg::t_out o_data
);

    // one result per transaction, fixed latency, when no reset intervened
    a_latency: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && $past(i_rst_n, 4))
        |-> (o_valid == $past(start && !busy, 4)))
        else $error("result strobe does not match transaction four cycles back");

    a_row_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.row_done == $past(i_data.row_end, 4)))
        else $error("row_done does not follow row_end");

    a_luma_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(i_data.op, 4)) |-> (o_data.second_value == '0))
        else $error("second_value nonzero for a luma transaction");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("transaction refused");

endmodule

bind rgb_to_yuv_matrix_convert_top ryc_checker u_ryc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_data  (i_data),
    .o_valid (o_valid),
    .o_data  (o_data)
);
